[src/pdc_pkg.sv]
package pdc_pkg;

  localparam int unsigned PedalMax = 256;
  localparam int unsigned RegenLast = 50;
  localparam int unsigned DriveFirst = 100;
  localparam int unsigned DriveSpan = PedalMax - DriveFirst;

  typedef enum logic [1:0] {
    CFG_PID_ENABLE = 2'd0,
    CFG_GAIN_PROP  = 2'd1,
    CFG_GAIN_INTEG = 2'd2,
    CFG_GAIN_DERIV = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic        pid_enable;
    logic [15:0] gain_prop;
    logic [15:0] gain_integ;
    logic [15:0] gain_deriv;
  } cfg_t;

  typedef struct packed {
    logic [8:0] pedal;
    logic [7:0] speed;
    logic       up;
    logic       down;
  } front_t;

  typedef struct packed {
    logic               use_pid;
    logic [8:0]         curve_thr;
    logic [8:0]         regen;
    logic signed [9:0]  cruise;
    logic signed [21:0] prop;
    logic signed [21:0] integ;
    logic signed [22:0] deriv;
  } prod_t;

  typedef logic [8:0]  regen_tab_t  [0:RegenLast];
  typedef logic [8:0]  power_tab_t  [0:DriveSpan];
  typedef logic [15:0] target_tab_t [0:DriveSpan];

  // Regen curve: floor(79.159 * n^0.3) for n = 50 - pedal.
  function automatic regen_tab_t build_regen_tab();
    regen_tab_t tab;
    real        v;
    for (int n = 0; n <= RegenLast; n++) begin
      v = 79.159 * $pow(real'(n), 0.3);
      tab[n] = 9'($rtoi(v));
    end
    return tab;
  endfunction

  // Power curve: 256 - ceil(56.27610464 * n^0.3) for n = 256 - pedal, floored at zero.
  function automatic power_tab_t build_power_tab();
    power_tab_t tab;
    real        v;
    int         c;
    for (int n = 0; n <= DriveSpan; n++) begin
      v = 56.27610464 * $pow(real'(n), 0.3);
      c = (n == 0) ? 0 : $rtoi(v) + 1;
      tab[n] = (c >= 256) ? 9'd0 : 9'(256 - c);
    end
    return tab;
  endfunction

  // Speed target in Q.8: floor(i * 255 * 256 / 156) for i = pedal - 100.
  function automatic target_tab_t build_target_tab();
    target_tab_t tab;
    for (int i = 0; i <= DriveSpan; i++) begin
      tab[i] = 16'((i * 255 * 256) / DriveSpan);
    end
    return tab;
  endfunction

  localparam regen_tab_t  RegenTab  = build_regen_tab();
  localparam power_tab_t  PowerTab  = build_power_tab();
  localparam target_tab_t TargetTab = build_target_tab();

  localparam logic signed [22:0] IntegLimit = 23'sd65280;

endpackage

[src/pdc_prod.sv]
module pdc_prod (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pdc_pkg::cfg_t   cfg_i,
  input  logic            s1_valid_i,
  input  pdc_pkg::front_t s1_i,
  input  logic            acc_ready_i,
  output logic            prod_ready_o,
  output logic            s2_valid_o,
  output pdc_pkg::prod_t  s2_o
);

  logic               s2_valid_q;
  pdc_pkg::prod_t     s2_q;
  pdc_pkg::prod_t     s2_d;
  logic signed [17:0] prev_error_q;
  logic signed [17:0] prev_error_d;

  logic               in_regen;
  logic               in_drive;
  logic [5:0]         regen_idx;
  logic [7:0]         power_idx;
  logic [7:0]         target_idx;
  logic [15:0]        target;
  logic signed [17:0] error;
  logic signed [18:0] diff;
  logic [16:0]        err_mag;
  logic [17:0]        diff_mag;
  logic [32:0]        prop_full;
  logic [32:0]        integ_full;
  logic [33:0]        deriv_full;
  logic signed [21:0] prop_pos;
  logic signed [21:0] integ_pos;
  logic signed [22:0] deriv_pos;
  logic               load;

  assign prod_ready_o = !s2_valid_q || acc_ready_i;
  assign load         = prod_ready_o && s1_valid_i;

  assign in_regen   = s1_i.pedal <= 9'(pdc_pkg::RegenLast);
  assign in_drive   = s1_i.pedal >= 9'(pdc_pkg::DriveFirst);
  assign regen_idx  = 6'(9'(pdc_pkg::RegenLast) - s1_i.pedal);
  assign power_idx  = 8'(9'(pdc_pkg::PedalMax) - s1_i.pedal);
  assign target_idx = 8'(s1_i.pedal - 9'(pdc_pkg::DriveFirst));
  assign target     = in_drive ? pdc_pkg::TargetTab[target_idx] : 16'd0;

  assign error = $signed({2'b00, target}) - $signed({2'b00, s1_i.speed, 8'h00});
  assign diff  = $signed({error[17], error}) - $signed({prev_error_q[17], prev_error_q});

  assign err_mag  = error[17] ? 17'(-error) : 17'(error);
  assign diff_mag = diff[18] ? 18'(-diff) : 18'(diff);

  assign prop_full  = 33'(err_mag) * 33'(cfg_i.gain_prop);
  assign integ_full = 33'(err_mag) * 33'(cfg_i.gain_integ);
  assign deriv_full = 34'(diff_mag) * 34'(cfg_i.gain_deriv);

  assign prop_pos  = $signed({1'b0, prop_full[32:12]});
  assign integ_pos = $signed({1'b0, integ_full[32:12]});
  assign deriv_pos = $signed({1'b0, deriv_full[33:12]});

  always_comb begin
    s2_d.use_pid   = cfg_i.pid_enable && in_drive;
    s2_d.curve_thr = in_drive ? pdc_pkg::PowerTab[power_idx] : 9'd0;
    s2_d.regen     = in_regen ? pdc_pkg::RegenTab[regen_idx] : 9'd0;
    s2_d.cruise    = $signed({2'b00, s1_i.speed}) + $signed({9'd0, s1_i.up})
                     - $signed({9'd0, s1_i.down});
    s2_d.prop      = error[17] ? -prop_pos : prop_pos;
    s2_d.integ     = error[17] ? -integ_pos : integ_pos;
    s2_d.deriv     = diff[18] ? -deriv_pos : deriv_pos;
    prev_error_d   = (load && s2_d.use_pid) ? error : prev_error_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q   <= 1'b0;
      prev_error_q <= '0;
    end else begin
      prev_error_q <= prev_error_d;
      if (prod_ready_o) begin
        s2_valid_q <= s1_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s2_q <= s2_d;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

endmodule

[src/pdc_acc.sv]
module pdc_acc (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s2_valid_i,
  input  pdc_pkg::prod_t       s2_i,
  input  logic                 out_stall_i,
  output logic                 acc_ready_o,
  output logic                 out_valid_o,
  output logic [8:0]           throttle_o,
  output logic [8:0]           regen_o,
  output logic signed [9:0]    cruise_speed_o
);

  logic               out_valid_q;
  logic [8:0]         throttle_q;
  logic [8:0]         throttle_d;
  logic [8:0]         regen_q;
  logic signed [9:0]  cruise_q;
  logic signed [17:0] integ_sum_q;
  logic signed [17:0] integ_sum_d;
  logic signed [22:0] integ;
  logic signed [24:0] sum;
  logic [8:0]         pid_thr;
  logic               load;

  assign acc_ready_o = !out_valid_q || !out_stall_i;
  assign load        = acc_ready_o && s2_valid_i;

  assign integ = $signed({{5{integ_sum_q[17]}}, integ_sum_q})
                 + $signed({s2_i.integ[21], s2_i.integ});
  assign sum   = $signed({{3{s2_i.prop[21]}}, s2_i.prop})
                 + $signed({{2{integ[22]}}, integ})
                 + $signed({{2{s2_i.deriv[22]}}, s2_i.deriv});

  always_comb begin
    priority if (sum >= 25'sd65536) begin
      pid_thr = 9'd255;
    end else if (sum <= 25'sd0) begin
      pid_thr = 9'd0;
    end else begin
      pid_thr = {1'b0, sum[15:8]};
    end

    throttle_d  = s2_i.use_pid ? pid_thr : s2_i.curve_thr;
    integ_sum_d = integ_sum_q;
    if (load && s2_i.use_pid) begin
      priority if (integ > pdc_pkg::IntegLimit) begin
        integ_sum_d = 18'(pdc_pkg::IntegLimit);
      end else if (integ < -pdc_pkg::IntegLimit) begin
        integ_sum_d = 18'(-pdc_pkg::IntegLimit);
      end else begin
        integ_sum_d = 18'(integ);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integ_sum_q <= '0;
    end else begin
      integ_sum_q <= integ_sum_d;
      if (acc_ready_o) begin
        out_valid_q <= s2_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      throttle_q <= throttle_d;
      regen_q    <= s2_i.regen;
      cruise_q   <= s2_i.cruise;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign throttle_o     = throttle_q;
  assign regen_o        = regen_q;
  assign cruise_speed_o = cruise_q;

endmodule

[src/pedal_to_drive_command_top.sv]
// One-pedal drive command generator. Each item carries a pedal sample, the measured speed and
// the cruise buttons, and yields throttle, regen and a cruise target speed. The pedal is held
// at 256 at most; up to 50 it gives regen from a fixed curve, from 100 it gives throttle from
// either a fixed power curve or, with pid_enable set, a PID speed loop whose gains are Q4.12.
// The block is a three-register pipeline (input, products, result) and accepts one item every
// clock cycle while the output is not stalled; each item passes through the input, product and
// result registers in that order. The PID state carries from one PID item to the next without
// a gap, since the derivative term and the integral each close in a single stage. Configuration
// writes should be made only while no item is in flight.
module pedal_to_drive_command_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [8:0]        pedal_i,
  input  logic [7:0]        measured_speed_i,
  input  logic              cruise_up_i,
  input  logic              cruise_down_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [8:0]        throttle_o,
  output logic [8:0]        regen_o,
  output logic signed [9:0] cruise_speed_o
);

  pdc_pkg::cfg_t   cfg_q;
  logic            s1_valid_q;
  pdc_pkg::front_t s1_q;
  pdc_pkg::front_t s1_d;
  logic            s1_ready;
  logic            prod_ready;
  logic            acc_ready;
  logic            s2_valid;
  pdc_pkg::prod_t  s2;
  logic            accept;

  assign s1_ready   = !s1_valid_q || prod_ready;
  assign in_stall_o = !s1_ready;
  assign accept     = in_valid_i && s1_ready;

  always_comb begin
    s1_d.pedal = (pedal_i > 9'(pdc_pkg::PedalMax)) ? 9'(pdc_pkg::PedalMax) : pedal_i;
    s1_d.speed = measured_speed_i;
    s1_d.up    = cruise_up_i;
    s1_d.down  = cruise_down_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pid_enable <= 1'b0;
      cfg_q.gain_prop  <= 16'd205;
      cfg_q.gain_integ <= 16'd205;
      cfg_q.gain_deriv <= 16'd205;
      s1_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (pdc_pkg::cfg_idx_e'(cfg_idx_i))
          pdc_pkg::CFG_PID_ENABLE: cfg_q.pid_enable <= cfg_data_i[0];
          pdc_pkg::CFG_GAIN_PROP:  cfg_q.gain_prop  <= cfg_data_i;
          pdc_pkg::CFG_GAIN_INTEG: cfg_q.gain_integ <= cfg_data_i;
          pdc_pkg::CFG_GAIN_DERIV: cfg_q.gain_deriv <= cfg_data_i;
          default: ;
        endcase
      end
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  pdc_prod u_prod (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .s1_valid_i   (s1_valid_q),
    .s1_i         (s1_q),
    .acc_ready_i  (acc_ready),
    .prod_ready_o (prod_ready),
    .s2_valid_o   (s2_valid),
    .s2_o         (s2)
  );

  pdc_acc u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s2_valid_i     (s2_valid),
    .s2_i           (s2),
    .out_stall_i    (out_stall_i),
    .acc_ready_o    (acc_ready),
    .out_valid_o    (out_valid_o),
    .throttle_o     (throttle_o),
    .regen_o        (regen_o),
    .cruise_speed_o (cruise_speed_o)
  );

  a_drive_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (throttle_o != 9'd0) |-> (regen_o == 9'd0))
    else $error("throttle and regen both active");

  a_cruise_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cruise_speed_o >= -10'sd1) && (cruise_speed_o <= 10'sd256))
    else $error("cruise speed out of range");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid && out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule

[verif/pedal_to_drive_command_top_tb.sv]
module pedal_to_drive_command_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam longint IntegCap = 255 * 256;

  typedef struct packed {
    logic [8:0]        throttle;
    logic [8:0]        regen;
    logic signed [9:0] cruise;
  } drive_cmd_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_idx_i = pdc_pkg::CFG_PID_ENABLE;
  logic [15:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [8:0]        pedal_i = '0;
  logic [7:0]        measured_speed_i = '0;
  logic              cruise_up_i = 1'b0;
  logic              cruise_down_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [8:0]        throttle_o;
  logic [8:0]        regen_o;
  logic signed [9:0] cruise_speed_o;

  pdc_pkg::cfg_t drive_cfg = '{1'b0, 16'd205, 16'd205, 16'd205};
  longint        prev_err = 0;
  longint        integ_acc = 0;
  logic [8:0]    regen_lut [0:pdc_pkg::RegenLast];
  logic [8:0]    power_lut [0:pdc_pkg::DriveSpan];
  drive_cmd_t    pending_cmds [$];
  bit            steady_flow = 1'b0;
  int            fail_cnt = 0;
  int            cycle_cnt = 0;
  int            stall_left = 0;

  pedal_to_drive_command_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pedal_i         (pedal_i),
    .measured_speed_i(measured_speed_i),
    .cruise_up_i     (cruise_up_i),
    .cruise_down_i   (cruise_down_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .throttle_o      (throttle_o),
    .regen_o         (regen_o),
    .cruise_speed_o  (cruise_speed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("pedal_to_drive_command_top verification failed");
      $finish;
    end
  end

  // Sign of k - (f1 * f2 / den) * n^0.3, decided exactly on tenth powers.
  function automatic int pow03_cmp(input int unsigned k, input int unsigned n,
                                   input int unsigned f1, input int unsigned f2,
                                   input int unsigned den);
    logic [383:0] lhs;
    logic [383:0] rhs;
    lhs = 384'd1;
    rhs = 384'd1;
    for (int i = 0; i < 10; i++) begin
      lhs = lhs * 384'(k);
      lhs = lhs * 384'(den);
      rhs = rhs * 384'(f1);
      rhs = rhs * 384'(f2);
    end
    for (int i = 0; i < 3; i++) begin
      rhs = rhs * 384'(n);
    end
    if (lhs < rhs) begin
      return -1;
    end else if (lhs > rhs) begin
      return 1;
    end
    return 0;
  endfunction

  function automatic int unsigned pow03_floor(input int unsigned n, input int unsigned f1,
                                              input int unsigned f2, input int unsigned den,
                                              output bit exact);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = 511;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (pow03_cmp(mid, n, f1, f2, den) <= 0) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    exact = (pow03_cmp(lo, n, f1, f2, den) == 0);
    return lo;
  endfunction

  task automatic build_curve_luts();
    bit          exact;
    int unsigned f;
    int unsigned c;
    for (int n = 0; n <= pdc_pkg::RegenLast; n++) begin
      regen_lut[n] = 9'(pow03_floor(n, 79159, 1, 1000, exact));
    end
    for (int n = 0; n <= pdc_pkg::DriveSpan; n++) begin
      f = pow03_floor(n, 32, 175862827, 100000000, exact);
      c = exact ? f : f + 1;
      power_lut[n] = (c >= 256) ? 9'd0 : 9'(256 - c);
    end
  endtask

  function automatic longint scale_gain(input logic [15:0] g, input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag * longint'(g)) >> 12;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic drive_cmd_t predict_drive_cmd(input logic [8:0] pedal_raw,
                                                   input logic [7:0] speed,
                                                   input logic up, input logic down);
    drive_cmd_t  cmd;
    int unsigned pedal;
    longint      target;
    longint      err;
    longint      integ;
    longint      sum;
    longint      whole;
    pedal = (pedal_raw > pdc_pkg::PedalMax) ? pdc_pkg::PedalMax : int'(pedal_raw);
    cmd.throttle = '0;
    cmd.regen = '0;
    if (pedal <= pdc_pkg::RegenLast) begin
      cmd.regen = regen_lut[pdc_pkg::RegenLast - pedal];
    end else if (pedal >= pdc_pkg::DriveFirst) begin
      if (!drive_cfg.pid_enable) begin
        cmd.throttle = power_lut[pdc_pkg::PedalMax - pedal];
      end else begin
        target = longint'(((pedal - pdc_pkg::DriveFirst) * 255 * 256) / pdc_pkg::DriveSpan);
        err = target - longint'(speed) * 256;
        integ = integ_acc + scale_gain(drive_cfg.gain_integ, err);
        sum = scale_gain(drive_cfg.gain_prop, err) + integ +
              scale_gain(drive_cfg.gain_deriv, err - prev_err);
        whole = sum / 256;
        if (integ > IntegCap) begin
          integ = IntegCap;
        end else if (integ < -IntegCap) begin
          integ = -IntegCap;
        end
        integ_acc = integ;
        prev_err = err;
        if (whole > 255) begin
          cmd.throttle = 9'd255;
        end else if (whole < 0) begin
          cmd.throttle = 9'd0;
        end else begin
          cmd.throttle = 9'(whole);
        end
      end
    end
    cmd.cruise = 10'(int'(speed) + int'(up) - int'(down));
    return cmd;
  endfunction

  function automatic int draw_wait();
    return steady_flow ? 0 : int'($urandom_range(0, 6));
  endfunction

  always @(posedge clk_i) begin : result_check
    drive_cmd_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_cmds.size() == 0) begin
          $error("result arrived with no item outstanding");
          fail_cnt++;
        end else begin
          want = pending_cmds.pop_front();
          if (throttle_o !== want.throttle) begin
            $error("throttle mismatch: expected %0d, got %0d", want.throttle, throttle_o);
            fail_cnt++;
          end
          if (regen_o !== want.regen) begin
            $error("regen mismatch: expected %0d, got %0d", want.regen, regen_o);
            fail_cnt++;
          end
          if (cruise_speed_o !== want.cruise) begin
            $error("cruise_speed mismatch: expected %0d, got %0d", want.cruise,
                   cruise_speed_o);
            fail_cnt++;
          end
        end
        stall_left = draw_wait();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left > 0);
    end
  end

  task automatic send_sample(input logic [8:0] pedal, input logic [7:0] speed,
                             input logic up, input logic down);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pedal_i <= pedal;
    measured_speed_i <= speed;
    cruise_up_i <= up;
    cruise_down_i <= down;
    do @(posedge clk_i); while (in_stall_o);
    pending_cmds.push_back(predict_drive_cmd(pedal, speed, up, down));
  endtask

  task automatic send_random_sample(input bit drive_heavy);
    logic [8:0] pedal;
    case ($urandom_range(0, drive_heavy ? 7 : 3))
      0: begin
        pedal = 9'($urandom_range(0, pdc_pkg::RegenLast));
      end
      1: begin
        pedal = 9'($urandom_range(pdc_pkg::RegenLast + 1, pdc_pkg::DriveFirst - 1));
      end
      2: begin
        pedal = 9'($urandom_range(0, 511));
      end
      default: begin
        pedal = 9'($urandom_range(pdc_pkg::DriveFirst, pdc_pkg::PedalMax));
      end
    endcase
    send_sample(pedal, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic drain_pipeline();
    if (in_valid_i) begin
      in_valid_i <= 1'b0;
    end
    while (pending_cmds.size() != 0) @(posedge clk_i);
  endtask

  task automatic put_reg(input pdc_pkg::cfg_idx_e idx, input logic [15:0] value);
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic load_settings(input logic pid, input logic [15:0] gp,
                               input logic [15:0] gi, input logic [15:0] gd);
    cfg_we_i <= 1'b1;
    put_reg(pdc_pkg::CFG_PID_ENABLE, {15'($urandom), pid});
    put_reg(pdc_pkg::CFG_GAIN_PROP, gp);
    put_reg(pdc_pkg::CFG_GAIN_INTEG, gi);
    put_reg(pdc_pkg::CFG_GAIN_DERIV, gd);
    cfg_we_i <= 1'b0;
    drive_cfg.pid_enable = pid;
    drive_cfg.gain_prop = gp;
    drive_cfg.gain_integ = gi;
    drive_cfg.gain_deriv = gd;
  endtask

  task automatic run_pid_phase(input logic [15:0] gp, input logic [15:0] gi,
                               input logic [15:0] gd, input int count);
    drain_pipeline();
    load_settings(1'b1, gp, gi, gd);
    repeat (count) send_random_sample(1'b1);
  endtask

  task automatic test_directed_power_curve();
    send_sample(9'd0, 8'd0, 1'b0, 1'b0);
    send_sample(9'd1, 8'd255, 1'b1, 1'b0);
    send_sample(9'd25, 8'd0, 1'b0, 1'b1);
    send_sample(9'd50, 8'd128, 1'b1, 1'b1);
    send_sample(9'd51, 8'd77, 1'b0, 1'b0);
    send_sample(9'd75, 8'd170, 1'b1, 1'b0);
    send_sample(9'd99, 8'd85, 1'b0, 1'b1);
    send_sample(9'd100, 8'd255, 1'b0, 1'b1);
    send_sample(9'd101, 8'd1, 1'b1, 1'b0);
    send_sample(9'd200, 8'd42, 1'b0, 1'b0);
    send_sample(9'd255, 8'd254, 1'b1, 1'b1);
    send_sample(9'd256, 8'd0, 1'b0, 1'b0);
    send_sample(9'd257, 8'd15, 1'b1, 1'b0);
    send_sample(9'd384, 8'd240, 1'b0, 1'b1);
    send_sample(9'd511, 8'd255, 1'b1, 1'b0);
  endtask

  task automatic test_directed_pid();
    drain_pipeline();
    load_settings(1'b1, 16'd205, 16'd205, 16'd205);
    send_sample(9'd100, 8'd255, 1'b0, 1'b0);
    send_sample(9'd511, 8'd0, 1'b1, 1'b0);
    send_sample(9'd256, 8'd0, 1'b0, 1'b0);
    send_sample(9'd30, 8'd60, 1'b0, 1'b1);
    send_sample(9'd178, 8'd100, 1'b0, 1'b1);
    send_sample(9'd60, 8'd10, 1'b1, 1'b1);
    send_sample(9'd300, 8'd255, 1'b1, 1'b1);
    send_sample(9'd150, 8'd81, 1'b0, 1'b0);
  endtask

  task automatic test_random_power_curve();
    drain_pipeline();
    load_settings(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
    repeat (200) send_random_sample(1'b0);
  endtask

  task automatic test_random_pid();
    run_pid_phase(16'd205, 16'd205, 16'd205, 100);
    run_pid_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 100);
    run_pid_phase(16'd0, 16'd0, 16'd0, 100);
    run_pid_phase(16'd4096, 16'd2048, 16'd0, 100);
    run_pid_phase(16'($urandom), 16'($urandom), 16'($urandom), 100);
  endtask

  task automatic test_steady_flow();
    drain_pipeline();
    steady_flow = 1'b1;
    run_pid_phase(16'($urandom_range(0, 8191)), 16'($urandom_range(0, 8191)),
                  16'($urandom_range(0, 8191)), 40);
    drain_pipeline();
    load_settings(1'b0, 16'd205, 16'd205, 16'd205);
    repeat (30) send_random_sample(1'b0);
    drain_pipeline();
    steady_flow = 1'b0;
  endtask

  initial begin
    build_curve_luts();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_power_curve();
    test_directed_pid();
    test_random_power_curve();
    test_random_pid();
    test_steady_flow();
    drain_pipeline();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("pedal_to_drive_command_top verification clean");
    end else begin
      $display("pedal_to_drive_command_top verification failed");
    end
    $finish;
  end

endmodule
